// File: src/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies; imported by every module in src.
package ffha_pkg;

  typedef struct packed {
    logic        opcode;
    logic [13:0] request_size;
    logic [13:0] payload_offset;
  } ffha_in_t;

  typedef struct packed {
    logic [13:0] granted_offset;
    logic [1:0]  status;
  } ffha_out_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam int HEAP_RESET = 16384;
  localparam int MIN_HEAP   = 64;

  // allocation granule; request rounding is a shift, so a power of two
  localparam int GRANULE_BYTES = 16;

endpackage

// File: src/ffha_table.sv
// Segment table memory: size and free mark per entry, one write and one
// registered read per cycle. Depends on ffha_pkg for nothing but style.
module ffha_table import ffha_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int SW    = 21
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [SW-1:0]            wsize,
  input  logic                     wfree,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [SW-1:0]            rsize,
  output logic                     rfree
);

  logic [SW:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wfree, wsize};
    end
    {rfree, rsize} <= mem[raddr];
  end

endmodule

// File: src/first_fit_heap_allocator_top.sv
// First-fit heap allocator with coalescing over an address-ordered table.
// Each beat walks the segments in address order; a split or merge shifts the
// later table entries by one.
// Beats are taken one at a time; in_stall is high while an item is in work.
// Reset (rst, synchronous) and writes of heap_bytes restart the table as one
// free segment; entries past segment_count are never used, so no clear pass.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int MAX_HEAP_BYTES = 16384,
  parameter int MAX_SEGMENTS   = 1024,
  parameter int HEADER_BYTES   = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffha_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ffha_out_t out_data
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  // wide enough for the heap and for a rounded 14-bit request
  localparam int SW = ($clog2(MAX_HEAP_BYTES + 1) + 1 > 16) ?
                      $clog2(MAX_HEAP_BYTES + 1) + 1 : 16;
  localparam int GSH = $clog2(GRANULE_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2,
    S_SHR = 4'd3, S_SHW = 4'd4, S_NXR = 4'd5, S_NXC = 4'd6, S_RMR = 4'd7,
    S_RMW = 4'd8, S_PVR = 4'd9, S_PVC = 4'd10, S_OUT = 4'd11, S_INIT = 4'd12;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] j;
  logic [SW-1:0] pos;
  logic [SW-1:0] need;
  logic [SW-1:0] cur_size;
  logic [SW-1:0] ins_size;
  logic          op;
  logic [13:0]   off;
  logic [14:0]   heap;
  logic          ins_pend;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wsize, rsize;
  logic          wfree, rfree;

  ffha_table #(.DEPTH(MAX_SEGMENTS), .SW(SW)) u_table (
    .clk, .we, .waddr, .wsize, .wfree, .raddr, .rsize, .rfree
  );

  // clamped heap size
  logic [SW-1:0] heap_eff;
  always_comb begin
    heap_eff = SW'(heap);
    if (heap < 15'(MIN_HEAP)) heap_eff = SW'(MIN_HEAP);
    if (SW'(heap) > SW'(MAX_HEAP_BYTES)) heap_eff = SW'(MAX_HEAP_BYTES);
  end

  logic [SW-1:0] rounded;
  assign rounded = ((SW'(in_data.request_size) + SW'(GRANULE_BYTES - 1)) >> GSH) << GSH;

  assign in_stall = (state != S_IDLE) || out_valid || cfg_we;

  // allocation and release sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; count <= CW'(1); heap <= 15'(HEAP_RESET);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          state <= S_IDLE; count <= CW'(1);
        end
        S_IDLE: begin
          if (cfg_we) begin
            heap <= cfg_wdata; state <= S_INIT;
          end else if (in_valid && !in_stall) begin
            op <= in_data.opcode; off <= in_data.payload_offset;
            need <= rounded; idx <= '0; pos <= '0; ins_pend <= 1'b0;
            if (in_data.opcode == OP_ALLOC && in_data.request_size == 14'd0) begin
              out_data <= '{granted_offset: 14'd0, status: ST_ZERO};
              out_valid <= 1'b1;
            end else state <= S_RD;
          end
        end
        // walked off the end: answer at once, the table is untouched
        S_RD: begin
          if (idx >= count) begin
            out_data <= '{granted_offset: 14'd0,
                          status: (op == OP_ALLOC) ? ST_NOMEM : ST_UNKNOWN};
            out_valid <= 1'b1; state <= S_IDLE;
          end else state <= S_CHK;
        end
        S_CHK: begin
          cur_size <= rsize;
          if (op == OP_ALLOC) begin
            if (rfree && rsize >= need) begin
              out_data <= '{granted_offset: 14'(pos + SW'(HEADER_BYTES)), status: ST_OK};
              if (rsize >= need + SW'(HEADER_BYTES + GRANULE_BYTES)
                  && count < CW'(MAX_SEGMENTS)) begin
                ins_size <= rsize - need - SW'(HEADER_BYTES);
                ins_pend <= 1'b1; j <= count; state <= S_SHR;
              end else state <= S_OUT;
            end else begin
              pos <= pos + SW'(HEADER_BYTES) + rsize; idx <= idx + CW'(1); state <= S_RD;
            end
          end else begin
            if (pos + SW'(HEADER_BYTES) == SW'(off)) begin
              if (rfree) begin
                out_data <= '{granted_offset: 14'd0, status: ST_UNKNOWN};
                state <= S_OUT;
              end else begin
                out_data <= '{granted_offset: 14'd0, status: ST_OK};
                state <= S_NXR;
              end
            end else begin
              pos <= pos + SW'(HEADER_BYTES) + rsize; idx <= idx + CW'(1); state <= S_RD;
            end
          end
        end
        // split: shift entries idx+1..count-1 up by one, top first
        S_SHR: state <= (j == idx + CW'(1)) ? S_OUT : S_SHW;
        S_SHW: begin j <= j - CW'(1); state <= S_SHR; end
        // release: look at successor
        S_NXR: state <= S_NXC;
        S_NXC: begin
          if (idx + CW'(1) < count && rfree) begin
            cur_size <= cur_size + SW'(HEADER_BYTES) + rsize;
            j <= idx + CW'(1); state <= S_RMR;
          end else begin
            j <= '0; state <= S_PVR;
          end
        end
        // remove entry: move j+1 down to j until the end
        S_RMR: begin
          if (j + CW'(1) >= count) begin
            count <= count - CW'(1); state <= (ins_pend) ? S_OUT : S_PVR;
          end else state <= S_RMW;
        end
        S_RMW: begin j <= j + CW'(1); state <= S_RMR; end
        S_PVR: state <= (idx == '0) ? S_OUT : S_PVC;
        S_PVC: begin
          if (rfree) begin
            cur_size <= rsize + SW'(HEADER_BYTES) + cur_size;
            idx <= idx - CW'(1); j <= idx; ins_pend <= 1'b1; state <= S_RMR;
          end else state <= S_OUT;
        end
        S_OUT: begin
          if (op == OP_ALLOC && ins_pend) count <= count + CW'(1);
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table port control
  always_comb begin
    we = 1'b0; waddr = '0; wsize = '0; wfree = 1'b0; raddr = AW'(idx);
    case (state)
      S_INIT: begin we = 1'b1; wsize = heap_eff - SW'(HEADER_BYTES); wfree = 1'b1; end
      S_SHR: begin raddr = AW'(j - CW'(1)); end
      S_SHW: begin we = 1'b1; waddr = AW'(j); wsize = rsize; wfree = rfree; end
      S_NXR: begin raddr = AW'(idx + CW'(1)); end
      S_RMR: begin raddr = AW'(j + CW'(1));
        we = 1'b1; waddr = AW'(idx);
        wsize = cur_size; wfree = 1'b1; end
      S_RMW: begin we = 1'b1; waddr = AW'(j); wsize = rsize; wfree = rfree; end
      S_PVR: begin raddr = AW'(idx - CW'(1));
        we = 1'b1; waddr = AW'(idx); wsize = cur_size; wfree = 1'b1; end
      S_OUT: begin
        we = 1'b1; waddr = AW'(idx);
        if (op == OP_ALLOC) begin
          wsize = ins_pend ? need : cur_size; wfree = 1'b0;
        end else begin
          wsize = cur_size; wfree = 1'b1;
        end
      end
      default: ;
    endcase
    // split: the new free remainder goes in at idx+1 once the shift is done
    if (state == S_SHR && j == idx + CW'(1)) begin
      we = 1'b1; waddr = AW'(idx + CW'(1)); wsize = ins_size; wfree = 1'b1;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped");

endmodule

// File: tb/sv/ffha_checker.sv
`timescale 1ns / 1ps
// Checker for the first-fit heap allocator: predicts each result beat
// from the accepted input beats and compares. Depends on ffha_pkg.
module ffha_checker import ffha_pkg::*; #(
  parameter int MAX_HEAP_BYTES = 16384,
  parameter int MAX_SEGMENTS   = 1024,
  parameter int HEADER_BYTES   = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  ffha_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  ffha_out_t   out_data,
  output int          errors,
  output int          pending
);

  // Shadow copy of the segment table
  int        seg_size [MAX_SEGMENTS];
  bit        seg_free [MAX_SEGMENTS];
  int        seg_count;
  ffha_out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic void restart_heap(input int heap);
    int h;
    h = heap;
    if (h < MIN_HEAP) h = MIN_HEAP;
    if (h > MAX_HEAP_BYTES) h = MAX_HEAP_BYTES;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_size[k] = 0;
      seg_free[k] = 1'b0;
    end
    seg_size[0] = h - HEADER_BYTES;
    seg_free[0] = 1'b1;
    seg_count   = 1;
  endfunction

  function automatic void drop_segment(input int i);
    for (int k = i; k < seg_count - 1; k++) begin
      seg_size[k] = seg_size[k + 1];
      seg_free[k] = seg_free[k + 1];
    end
    seg_count--;
    seg_size[seg_count] = 0;
    seg_free[seg_count] = 1'b0;
  endfunction

  function automatic void add_free_segment(input int i, input int size);
    for (int k = seg_count; k > i; k--) begin
      seg_size[k] = seg_size[k - 1];
      seg_free[k] = seg_free[k - 1];
    end
    seg_size[i] = size;
    seg_free[i] = 1'b1;
    seg_count++;
  endfunction

  // First fit with split of a large enough remainder
  function automatic ffha_out_t grant_block(input int req);
    ffha_out_t r;
    int need, pos;
    r = '0;
    pos = 0;
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = ((req + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
    for (int i = 0; i < seg_count; i++) begin
      if (seg_free[i] && seg_size[i] >= need) begin
        if (seg_size[i] >= need + HEADER_BYTES + GRANULE_BYTES &&
            seg_count < MAX_SEGMENTS) begin
          add_free_segment(i + 1, seg_size[i] - need - HEADER_BYTES);
          seg_size[i] = need;
        end
        seg_free[i] = 1'b0;
        r.granted_offset = 14'(pos + HEADER_BYTES);
        r.status = ST_OK;
        return r;
      end
      pos += HEADER_BYTES + seg_size[i];
    end
    r.status = ST_NOMEM;
    return r;
  endfunction

  // Release, then coalesce with successor and predecessor
  function automatic ffha_out_t release_block(input int off);
    ffha_out_t r;
    int pos, i;
    r = '0;
    pos = 0;
    for (i = 0; i < seg_count; i++) begin
      if (pos + HEADER_BYTES == off) break;
      pos += HEADER_BYTES + seg_size[i];
    end
    if (i >= seg_count || seg_free[i]) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    seg_free[i] = 1'b1;
    if (i + 1 < seg_count && seg_free[i + 1]) begin
      seg_size[i] += HEADER_BYTES + seg_size[i + 1];
      drop_segment(i + 1);
    end
    if (i > 0 && seg_free[i - 1]) begin
      seg_size[i - 1] += HEADER_BYTES + seg_size[i];
      drop_segment(i);
    end
    r.status = ST_OK;
    return r;
  endfunction

  // Input beats first, then the result beat of the same edge
  always @(posedge clk) begin
    ffha_out_t exp_r;
    if (rst) begin
      restart_heap(HEAP_RESET);
      expected_results.delete();
    end else begin
      if (cfg_we) restart_heap(int'(cfg_wdata));
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_ALLOC)
          expected_results.push_back(grant_block(int'(in_data.request_size)));
        else
          expected_results.push_back(release_block(int'(in_data.payload_offset)));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: offset %0d status %0d",
                 out_data.granted_offset, out_data.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.granted_offset !== exp_r.granted_offset) begin
            $error("granted_offset: expected %0d, actual %0d",
                   exp_r.granted_offset, out_data.granted_offset);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the first-fit heap allocator: clock, reset, stimulus
// and verdict. Depends on ffha_pkg, ffha_checker and the block itself.
module first_fit_heap_allocator_top_tb;
  import ffha_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ffha_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ffha_out_t   out_data;
  int          errors;
  int          pending;

  // Offsets currently held, as seen on result beats
  logic [13:0] live_offsets[$];
  logic [13:0] freed_offsets[$];
  logic        ops_in_flight[$];
  int          burst_left = 0;
  int          idle_cycles = 0;

  always #4 clk = ~clk;

  first_fit_heap_allocator_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ffha_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // Receiver stall: random, with a probability redrawn from 0, 25, 50 or 75 percent; sometimes none
  int stall_pct = 0;
  int stall_tick = 0;
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 0) stall_pct <= $urandom_range(0, 3) * 25;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Track grants so that releases can hit held blocks
  always @(posedge clk) begin
    logic op;
    if (!rst && out_valid && !out_stall && ops_in_flight.size() > 0) begin
      op = ops_in_flight.pop_front();
      if (op == OP_ALLOC && out_data.status == ST_OK)
        live_offsets.push_back(out_data.granted_offset);
    end
  end

  // Watchdog on cycles with no beat accepted anywhere
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one beat, with bursts and random gaps between them
  task automatic send_beat(input logic op, input int req, input int off);
    ffha_in_t beat;
    beat.opcode = op;
    beat.request_size = 14'(req);
    beat.payload_offset = 14'(off);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_in_flight.push_back(op);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic alloc_beat(input int req);
    send_beat(OP_ALLOC, req, $urandom_range(0, 16383));
  endtask

  task automatic release_beat(input int off);
    send_beat(OP_RELEASE, $urandom_range(0, 16383), off);
  endtask

  // Drain all results, then write heap_bytes
  task automatic set_heap(input int heap);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 15'(heap);
    @(negedge clk);
    cfg_we <= 1'b0;
    live_offsets.delete();
    freed_offsets.delete();
  endtask

  task automatic random_phase(input int count);
    int r, k;
    logic [13:0] off;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 85 && live_offsets.size() == 0)) begin
        if ($urandom_range(0, 9) == 0) alloc_beat($urandom_range(0, 16383));
        else alloc_beat($urandom_range(1, 256));
      end else if (r < 85) begin
        k = $urandom_range(0, live_offsets.size() - 1);
        off = live_offsets[k];
        live_offsets.delete(k);
        freed_offsets.push_back(off);
        release_beat(off);
      end else if (r < 92) begin
        release_beat($urandom_range(0, 16383));
      end else if (r < 96 && freed_offsets.size() > 0) begin
        release_beat(freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
      end else begin
        alloc_beat(0);
      end
    end
  endtask

  initial begin
    int heaps[6];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero size, splits, misses, double release, both merges
    alloc_beat(0);
    alloc_beat(1);
    alloc_beat(16);
    alloc_beat(17);
    alloc_beat(16383);
    release_beat(0);
    release_beat(5);
    release_beat(12);
    release_beat(12);
    release_beat(68);
    release_beat(40);
    alloc_beat(16372);
    alloc_beat(16368);
    release_beat(12);
    send_beat(OP_ALLOC, 100, 16383);
    send_beat(OP_RELEASE, 16383, 12);
    send_beat(OP_RELEASE, 0, 16383);

    // Several heap sizes, including both clamps
    heaps = '{64, 0, 32767, 16384, 1000, 0};
    heaps[5] = $urandom_range(0, 32767);
    foreach (heaps[h]) begin
      set_heap(heaps[h]);
      if (h == 0) begin
        alloc_beat(48);
        release_beat(12);
        alloc_beat(32);
        alloc_beat(16);
      end
      random_phase(45);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ffha_pkg.sv
src/ffha_table.sv
src/first_fit_heap_allocator_top.sv
tb/sv/ffha_checker.sv
tb/sv/first_fit_heap_allocator_top_tb.sv
